@@ src/etd_pkg.sv @@
// Shared types, character codes and hex helpers for the escaped text decoder.
`default_nettype none

package etd_pkg;

  // Decode modes held in the mode register.
  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_HEX     = 2'd1;
  localparam logic [1:0] MODE_PERCENT = 2'd2;
  localparam logic [1:0] MODE_CSTRING = 2'd3;

  // Escape phase codes, named by how many characters are held back.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HELD1 = 2'd1;
  localparam logic [1:0] PH_HELD2 = 2'd2;
  localparam logic [1:0] PH_HELD3 = 2'd3;

  // Register map, indexed by byte address bit 2.
  localparam logic REG_DECODE_MODE = 1'b0;

  // Character codes.
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2b;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_BSLASH  = 8'h5c;
  localparam logic [7:0] CHR_X       = 8'h78;

  localparam int unsigned MAX_BEATS = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } etd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_done;
  } etd_out_t;

  // Everything one input item produces: the burst of bytes and the next state.
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [2:0]                count;
    logic [1:0]                phase;
    logic [7:0]                held;
  } etd_step_t;

  typedef struct packed {
    logic [7:0] code;
    logic       valid;
  } etd_esc_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_val(hi), hex_val(lo)};
  endfunction

  // Single-character C escapes after a backslash.
  function automatic etd_esc_t esc_code(input logic [7:0] c);
    etd_esc_t r;
    r.valid = 1'b1;
    case (c)
      8'h5c: r.code = 8'h5c;
      8'h61: r.code = 8'h07;
      8'h62: r.code = 8'h08;
      8'h74: r.code = 8'h09;
      8'h6e: r.code = 8'h0a;
      8'h76: r.code = 8'h0b;
      8'h66: r.code = 8'h0c;
      8'h72: r.code = 8'h0d;
      8'h65: r.code = 8'h1b;
      default: begin
        r.valid = 1'b0;
        r.code  = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/etd_decode.sv @@
// Combinational decode of one input character against the escape state.
`default_nettype none

module etd_decode
  import etd_pkg::*;
(
  input  wire logic [1:0] mode_i,
  input  wire logic [1:0] phase_i,
  input  wire logic [7:0] held_i,
  input  wire etd_in_t    item_i,
  output etd_step_t       step_o
);

  logic [MAX_BEATS-1:0][7:0] em;
  logic [2:0]                n;
  logic [1:0]                ph;
  logic [7:0]                hd;
  logic                      run_idle;
  logic [7:0]                b;
  logic                      hx;
  etd_esc_t                  esc;

  always_comb begin
    em       = '0;
    n        = 3'd0;
    ph       = phase_i;
    hd       = held_i;
    run_idle = 1'b0;
    b        = item_i.in_byte;
    hx       = is_hex(b);
    esc      = esc_code(b);

    // Continue an open escape.
    if (mode_i == MODE_HEX && phase_i == PH_HELD1) begin
      if (hx) begin
        em[n[1:0]] = pair_val(held_i, b); n = n + 3'd1;
      end
      ph = PH_IDLE;
    end else if (mode_i == MODE_PERCENT && phase_i == PH_HELD1) begin
      if (hx) begin
        hd = b; ph = PH_HELD2;
      end else begin
        em[n[1:0]] = CHR_PERCENT; n = n + 3'd1;
        run_idle = 1'b1;
      end
    end else if (mode_i == MODE_PERCENT && phase_i == PH_HELD2) begin
      if (hx) begin
        em[n[1:0]] = pair_val(held_i, b); n = n + 3'd1;
        ph = PH_IDLE;
      end else begin
        em[n[1:0]] = CHR_PERCENT; n = n + 3'd1;
        em[n[1:0]] = held_i;      n = n + 3'd1;
        run_idle = 1'b1;
      end
    end else if (mode_i == MODE_CSTRING && phase_i == PH_HELD1) begin
      if (esc.valid) begin
        em[n[1:0]] = esc.code; n = n + 3'd1;
        ph = PH_IDLE;
      end else if (b == CHR_X) begin
        ph = PH_HELD2;
      end else begin
        em[n[1:0]] = CHR_BSLASH; n = n + 3'd1;
        run_idle = 1'b1;
      end
    end else if (mode_i == MODE_CSTRING && phase_i == PH_HELD2) begin
      if (hx) begin
        hd = b; ph = PH_HELD3;
      end else begin
        em[n[1:0]] = CHR_BSLASH; n = n + 3'd1;
        em[n[1:0]] = CHR_X;      n = n + 3'd1;
        run_idle = 1'b1;
      end
    end else if (mode_i == MODE_CSTRING && phase_i == PH_HELD3) begin
      if (hx) begin
        em[n[1:0]] = pair_val(held_i, b); n = n + 3'd1;
        ph = PH_IDLE;
      end else begin
        em[n[1:0]] = CHR_BSLASH; n = n + 3'd1;
        em[n[1:0]] = CHR_X;      n = n + 3'd1;
        em[n[1:0]] = held_i;     n = n + 3'd1;
        run_idle = 1'b1;
      end
    end else begin
      run_idle = 1'b1;
    end

    // Handle the character as if no escape were open.
    if (run_idle) begin
      ph = PH_IDLE;
      case (mode_i)
        MODE_HEX: begin
          if (hx) begin
            hd = b; ph = PH_HELD1;
          end
        end
        MODE_PERCENT: begin
          if (b == CHR_PERCENT) begin
            ph = PH_HELD1;
          end else if (b == CHR_PLUS) begin
            em[n[1:0]] = CHR_SPACE; n = n + 3'd1;
          end else begin
            em[n[1:0]] = b; n = n + 3'd1;
          end
        end
        MODE_CSTRING: begin
          if (b == CHR_BSLASH) begin
            ph = PH_HELD1;
          end else begin
            em[n[1:0]] = b; n = n + 3'd1;
          end
        end
        default: begin
          em[n[1:0]] = b; n = n + 3'd1;
        end
      endcase
    end

    // At end of text an open percent or C-string escape goes out unchanged; a lone hex digit is dropped.
    if (item_i.end_of_text) begin
      if (mode_i == MODE_PERCENT) begin
        if (ph == PH_HELD1) begin
          em[n[1:0]] = CHR_PERCENT; n = n + 3'd1;
        end else if (ph == PH_HELD2) begin
          em[n[1:0]] = CHR_PERCENT; n = n + 3'd1;
          em[n[1:0]] = hd;          n = n + 3'd1;
        end
      end else if (mode_i == MODE_CSTRING) begin
        if (ph == PH_HELD1) begin
          em[n[1:0]] = CHR_BSLASH; n = n + 3'd1;
        end else if (ph == PH_HELD2) begin
          em[n[1:0]] = CHR_BSLASH; n = n + 3'd1;
          em[n[1:0]] = CHR_X;      n = n + 3'd1;
        end else if (ph == PH_HELD3) begin
          em[n[1:0]] = CHR_BSLASH; n = n + 3'd1;
          em[n[1:0]] = CHR_X;      n = n + 3'd1;
          em[n[1:0]] = hd;         n = n + 3'd1;
        end
      end
      ph = PH_IDLE;
      hd = 8'h00;
    end

    step_o.bytes = em;
    step_o.count = n;
    step_o.phase = ph;
    step_o.held  = hd;
  end

endmodule

`default_nettype wire

@@ src/etd_burst.sv @@
// Result register that holds one item's burst of bytes and hands it out a beat at a time.
`default_nettype none

module etd_burst
  import etd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load_i,
  input  wire etd_step_t step_i,
  input  wire logic      eot_i,
  output logic           can_load_o,
  output logic           out_valid,
  input  wire logic      out_ready,
  output etd_out_t       out_data
);

  logic [MAX_BEATS-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]                rem_r, rem_nxt;
  logic                      has_r, has_nxt;
  logic                      eot_r, eot_nxt;
  logic                      busy;
  logic                      pop;

  assign busy       = (rem_r != 3'd0);
  assign pop        = busy && out_ready;
  assign can_load_o = !busy || (pop && rem_r == 3'd1);

  always_comb begin
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    has_nxt   = has_r;
    eot_nxt   = eot_r;
    if (load_i) begin
      bytes_nxt = step_i.bytes;
      eot_nxt   = eot_i;
      if (step_i.count == 3'd0 && eot_i) begin
        // Empty end marker.
        rem_nxt = 3'd1;
        has_nxt = 1'b0;
      end else begin
        rem_nxt = step_i.count;
        has_nxt = 1'b1;
      end
    end else if (pop) begin
      bytes_nxt = {8'h00, bytes_r[MAX_BEATS-1:1]};
      rem_nxt   = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      has_r <= 1'b0;
      eot_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      has_r <= has_nxt;
      eot_r <= eot_nxt;
    end
    bytes_r <= bytes_nxt;
  end

  assign out_valid          = busy;
  assign out_data.out_byte  = bytes_r[0];
  assign out_data.has_byte  = has_r;
  assign out_data.run_last  = (rem_r == 3'd1);
  assign out_data.text_done = (rem_r == 3'd1) && eot_r;

endmodule

`default_nettype wire

@@ src/escaped_text_decoder_core.sv @@
// Top level of the escaped text decoder: input register, decode, result burst, config port.
`default_nettype none

// The block decodes a stream of characters, one per input beat, in one of four
// modes chosen by the decode_mode register: raw copy, hex digit pairs, percent
// and plus decoding, or C-string backslash escapes.
// Input beats are taken on in_valid and in_ready; each carries one character
// and an end_of_text flag. Result beats leave on out_valid and out_ready, one
// decoded byte per beat, with run_last on the last beat of an input item and
// text_done on the last beat after an end_of_text item. An end_of_text item
// that yields no byte gives a single beat with has_byte low.
// An accepted item passes through the input register and then the result
// register. Items that yield zero or one result stream at one per cycle
// while out_ready stays high; an item that yields k results occupies the
// result register for k beats, up to four, and keeps the next item waiting.
// When the receiver stalls, the result register holds its beat and the input
// register fills, after which in_ready drops. Reset empties both registers,
// sets raw mode and clears the escape state. Writing decode_mode over the APB
// port also clears the escape state; writes are meant only while idle.
module escaped_text_decoder_core
  import etd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire etd_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output etd_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Input register.
  logic      in_valid_r;
  etd_in_t   in_r;

  // Configuration and escape state.
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  etd_step_t step;
  logic      can_load;
  logic      take;
  logic      cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_DECODE_MODE);
  assign prdata   = (paddr[2] == REG_DECODE_MODE) ? {30'd0, mode_r} : 32'd0;

  // The held item moves into the result register once that register is free
  // or is handing out its final beat in this cycle.
  assign take     = in_valid_r && can_load;
  assign in_ready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  etd_decode u_decode (
    .mode_i  (mode_r),
    .phase_i (phase_r),
    .held_i  (held_r),
    .item_i  (in_r),
    .step_o  (step)
  );

  // A mode write drops any open escape without output.
  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (cfg_wr) begin
      mode_nxt  = pwdata[1:0];
      phase_nxt = PH_IDLE;
      held_nxt  = 8'h00;
    end else if (take) begin
      phase_nxt = step.phase;
      held_nxt  = step.held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RAW;
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  etd_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (take),
    .step_i     (step),
    .eot_i      (in_r.end_of_text),
    .can_load_o (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // An end_of_text item always leaves the escape state idle.
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_r.end_of_text && !cfg_wr |=> phase_r == PH_IDLE)
    else $error("escape state open after end of text");

  // The end of a text is always the last beat of its item.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_done |-> out_data.run_last)
    else $error("text_done without run_last");

  // An empty beat is only ever the end marker.
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.text_done && out_data.out_byte == 8'h00)
    else $error("empty beat that is not an end marker");

  // An item never moves on while the receiver stalls a beat of the result register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !take)
    else $error("result burst overwritten while stalled");

endmodule

`default_nettype wire
